[rtl/fcr_pkg.sv]
`timescale 1ns / 1ps

package fcr_pkg;

  // Framing and primer characters.
  localparam logic [7:0] CH_START  = 8'h21;
  localparam logic [7:0] CH_END    = 8'h2A;
  localparam logic [7:0] CH_DELIM  = 8'h3B;
  localparam logic [7:0] CH_PRIMER = 8'h23;

  // Field splitting limits.
  localparam int FIELD_COUNT = 5;
  localparam int FIELD_CHARS = 10;
  localparam int IDX_W       = $clog2(FIELD_COUNT);
  localparam int POS_W       = $clog2(FIELD_CHARS);

  // Only the first three fields are ever compared, and no command text is
  // longer than four characters, so five bytes of each field decide a match.
  localparam int MATCH_FIELDS = 3;
  localparam int MATCH_CHARS  = 5;
  localparam int TXT_BITS     = 8 * MATCH_CHARS;

  localparam logic [TXT_BITS-1:0] TXT_END  = {"END", 16'h0000};
  localparam logic [TXT_BITS-1:0] TXT_DATA = {"Data", 8'h00};
  localparam logic [TXT_BITS-1:0] TXT_LEDB = {"LEDB", 8'h00};
  localparam logic [TXT_BITS-1:0] TXT_ON   = {"On", 24'h000000};
  localparam logic [TXT_BITS-1:0] TXT_OFF  = {"Off", 16'h0000};
  localparam logic [TXT_BITS-1:0] TXT_CONF = {"Conf", 8'h00};

  // Reply texts, left aligned in slots of the longest reply.
  localparam int REPLY_MAX  = 17;
  localparam int REPLY_BITS = 8 * REPLY_MAX;
  localparam int REPLY_CW   = $clog2(REPLY_MAX + 1);

  localparam logic [REPLY_BITS-1:0] RTXT_GREET   = "######!Read;LEDB*";
  localparam logic [REPLY_BITS-1:0] RTXT_SET_OFF = {"##!Set;LEDB;Off*", 8'h00};
  localparam logic [REPLY_BITS-1:0] RTXT_SET_ON  = {"##!Set;LEDB;On*", 16'h0000};
  localparam logic [REPLY_BITS-1:0] RTXT_END     = {"##!END*", 80'h0};

  typedef enum logic [2:0] {
    RPL_NONE,
    RPL_GREET,
    RPL_SET_OFF,
    RPL_SET_ON,
    RPL_END
  } reply_t;

  typedef enum logic [1:0] {
    FS_WAIT = 2'd0,
    FS_IN   = 2'd1,
    FS_DONE = 2'd2
  } frame_t;

  // Byte stream from the receive store into the field splitter.
  typedef struct packed {
    logic       start;
    logic       valid;
    logic [7:0] data;
  } scan_t;

  // Decoded command of a finished frame.
  typedef struct packed {
    reply_t reply;
    logic   end_cmd;
  } verdict_t;

  function automatic logic [REPLY_CW-1:0] reply_len(input reply_t kind);
    logic [REPLY_CW-1:0] len;
    case (kind)
      RPL_GREET:   len = REPLY_CW'(17);
      RPL_SET_OFF: len = REPLY_CW'(16);
      RPL_SET_ON:  len = REPLY_CW'(15);
      RPL_END:     len = REPLY_CW'(7);
      default:     len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] reply_char(input reply_t kind,
                                            input logic [REPLY_CW-1:0] i);
    logic [REPLY_BITS-1:0] txt;
    case (kind)
      RPL_GREET:   txt = RTXT_GREET;
      RPL_SET_OFF: txt = RTXT_SET_OFF;
      RPL_SET_ON:  txt = RTXT_SET_ON;
      RPL_END:     txt = RTXT_END;
      default:     txt = '0;
    endcase
    return txt[REPLY_BITS - 8 - 8 * i +: 8];
  endfunction

  // Whole-text compare: the first len bytes match and the next byte is zero.
  function automatic logic text_is(input logic [MATCH_CHARS-1:0][7:0] f,
                                   input logic [TXT_BITS-1:0] txt,
                                   input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < MATCH_CHARS; k++) begin
      if (k < int'(len)) begin
        if (f[k] != txt[8 * (MATCH_CHARS - 1 - k) +: 8]) ok = 1'b0;
      end else if (k == int'(len)) begin
        if (f[k] != 8'h00) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[rtl/framed_ascii_command_responder_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// -------   -------------------   ----------------------------------------
// in        in_valid / in_ready   restart, select_active, rx_valid, rx_byte
// out       out_valid / out_ready tx_load, tx_byte, frame_state, end_seen
//
// A request that neither restarts nor closes a frame passes through accept,
// transmit load from the ring memory, and the write into the output register.
// A closing '*' adds a scan of the receive memory, one read per cycle over
// the buffered bytes, and one ring write per reply byte (7-16).
// Reset, restart and a select assertion write the 17-byte greeting into the
// ring, one byte per cycle, while in_ready stays low.
// The next request is taken while an earlier result waits in the output
// register; a stalled output holds the block only at its final step.

module framed_ascii_command_responder_core
  import fcr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       restart,
  input  logic       select_active,
  input  logic       rx_valid,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_load,
  output logic [7:0] tx_byte,
  output logic [1:0] frame_state,
  output logic       end_seen
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_REPLY  = 5'b00100,
    S_LOAD   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t              state;
  frame_t              frame_status;
  logic [AW-1:0]       fill;
  logic [AW-1:0]       rp;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic                busy;
  logic                select_prev;
  logic                clear_pend;
  reply_t              kind;
  logic [REPLY_CW-1:0] cnt;
  logic                rd_pend;
  logic [7:0]          rx_q;
  logic [7:0]          ring_q;

  // Result under construction.
  logic                res_load;
  logic                res_from_ring;
  frame_t              res_fs;
  logic                res_end;

  // Output register.
  logic                out_load;
  logic [7:0]          out_byte;
  frame_t              out_fs;
  logic                out_end;

  logic [7:0]          rx_mem  [BUFFER_DEPTH];
  logic [7:0]          tx_ring [BUFFER_DEPTH];

  logic                accept;
  frame_t              fs0;
  frame_t              fs1;
  frame_t              fs2;
  logic                start_frame;
  logic [AW-1:0]       fill1;
  logic [AW-1:0]       fill2;
  logic                rx_wr;
  logic                rx_we;
  logic                rx_rd;
  logic                scan_done;
  logic                ring_we;
  logic                ring_rd;
  logic [7:0]          ring_wdata;
  logic                reply_last;
  logic                fin_fire;
  logic [AW-1:0]       tail_inc;
  logic [AW-1:0]       head_inc;
  scan_t               scan;
  verdict_t            verdict;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Framing of the received byte.
  assign fs0         = (frame_status == FS_DONE) ? FS_WAIT : frame_status;
  assign start_frame = rx_valid && (rx_byte == CH_START) && (fs0 != FS_IN);
  assign fs1         = start_frame ? FS_IN : fs0;
  assign fill1       = start_frame ? '0 : fill;
  assign rx_wr       = rx_valid && (fs1 == FS_IN);
  assign fill2       = !rx_wr ? fill1 :
                       (fill1 == LAST_ADDR) ? fill1 : fill1 + 1'b1;
  assign fs2         = (rx_wr && (rx_byte == CH_END)) ? FS_DONE : fs1;
  assign rx_we       = accept && !restart && rx_wr;

  // Scan of the closed frame, one memory read per cycle.
  assign rx_rd     = (state == S_SCAN) && (rp != fill);
  assign scan_done = (state == S_SCAN) && (rp == fill) && !rd_pend;

  assign scan.start = accept && !restart && (fs2 == FS_DONE);
  assign scan.valid = rd_pend;
  assign scan.data  = rx_q;

  fcr_split u_split (
    .clk     (clk),
    .rst     (rst),
    .scan    (scan),
    .verdict (verdict)
  );

  // Transmit ring pointers wrap at the buffer depth.
  assign tail_inc   = (tail == LAST_ADDR) ? '0 : tail + 1'b1;
  assign head_inc   = (head == LAST_ADDR) ? '0 : head + 1'b1;
  assign ring_we    = (state == S_REPLY);
  assign ring_wdata = reply_char(kind, cnt);
  assign reply_last = (cnt == REPLY_CW'(reply_len(kind) - 1'b1));
  assign ring_rd    = (state == S_LOAD) && !busy && (head != tail);
  assign fin_fire   = (state == S_FINISH) && (!out_valid || out_ready);

  // Receive store.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[fill1] <= rx_byte;
    end
    if (rx_rd) begin
      rx_q <= rx_mem[rp];
    end
  end

  // Transmit ring.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      tx_ring[tail] <= ring_wdata;
    end
    if (ring_rd) begin
      ring_q <= tx_ring[head];
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_REPLY;
      kind         <= RPL_GREET;
      cnt          <= '0;
      frame_status <= FS_WAIT;
      fill         <= '0;
      rp           <= '0;
      head         <= '0;
      tail         <= '0;
      busy         <= 1'b0;
      select_prev  <= 1'b0;
      clear_pend   <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= rx_rd;
      case (state)
        S_IDLE: begin
          if (accept) begin
            select_prev <= select_active;
            if (restart) begin
              clear_pend <= 1'b1;
              state      <= S_FINISH;
            end else begin
              clear_pend   <= select_active && !select_prev;
              frame_status <= fs2;
              fill         <= fill2;
              busy         <= rx_valid ? 1'b0 : busy;
              rp           <= '0;
              state        <= (fs2 == FS_DONE) ? S_SCAN : S_LOAD;
            end
          end
        end
        S_SCAN: begin
          if (rx_rd) begin
            rp <= rp + 1'b1;
          end else if (scan_done) begin
            kind  <= verdict.reply;
            cnt   <= '0;
            state <= (verdict.reply == RPL_NONE) ? S_LOAD : S_REPLY;
          end
        end
        S_REPLY: begin
          tail <= tail_inc;
          cnt  <= cnt + 1'b1;
          if (reply_last) begin
            state <= (kind == RPL_GREET) ? S_IDLE : S_LOAD;
          end
        end
        S_LOAD: begin
          if (!busy) begin
            busy <= 1'b1;
            if (head != tail) begin
              head <= head_inc;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (fin_fire) begin
            if (clear_pend) begin
              frame_status <= FS_WAIT;
              fill         <= '0;
              head         <= '0;
              tail         <= '0;
              busy         <= 1'b0;
              kind         <= RPL_GREET;
              cnt          <= '0;
              clear_pend   <= 1'b0;
              state        <= S_REPLY;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result fields gathered along the way.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_load      <= 1'b0;
      res_from_ring <= 1'b0;
      res_end       <= 1'b0;
      res_fs        <= restart ? FS_WAIT : fs2;
    end else if (scan_done) begin
      res_end <= verdict.end_cmd;
    end else if ((state == S_LOAD) && !busy) begin
      res_load      <= 1'b1;
      res_from_ring <= (head != tail);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_load <= res_load;
      out_byte <= res_from_ring ? ring_q : 8'h00;
      out_fs   <= res_fs;
      out_end  <= res_end;
    end
  end

  assign tx_load     = out_load;
  assign tx_byte     = out_byte;
  assign frame_state = out_fs;
  assign end_seen    = out_end;

endmodule

[rtl/fcr_split.sv]
`timescale 1ns / 1ps

module fcr_split
  import fcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  scan_t    scan,
  output verdict_t verdict
);

  logic [MATCH_CHARS-1:0][7:0] fld [MATCH_FIELDS];
  logic [IDX_W-1:0]            idx;
  logic [POS_W-1:0]            pos;
  logic [IDX_W-1:0]            idx_next;
  logic [POS_W-1:0]            pos_next;
  logic                        is_delim;
  logic                        is_text;
  logic                        f0_data;

  // Classify the incoming byte; start and end marks carry no text.
  assign is_delim = scan.valid && (scan.data == CH_DELIM);
  assign is_text  = scan.valid && (scan.data != CH_DELIM) &&
                    (scan.data != CH_START) && (scan.data != CH_END);

  // Field index and character position both saturate.
  assign idx_next = (idx == IDX_W'(FIELD_COUNT - 1)) ? idx : idx + 1'b1;
  assign pos_next = (pos == POS_W'(FIELD_CHARS - 1)) ? pos : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || scan.start) begin
      idx <= '0;
      pos <= '0;
    end else if (is_delim) begin
      idx <= idx_next;
      pos <= '0;
    end else if (is_text) begin
      pos <= pos_next;
    end
  end

  // Write the character and terminate the text behind it. At a saturated
  // position the terminator lands on the character itself.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MATCH_FIELDS; j++) begin
      for (int k = 0; k < MATCH_CHARS; k++) begin
        if (scan.start) begin
          fld[j][k] <= 8'h00;
        end else if (is_text && (idx == IDX_W'(j))) begin
          if (pos_next == POS_W'(k)) begin
            fld[j][k] <= 8'h00;
          end else if (pos == POS_W'(k)) begin
            fld[j][k] <= scan.data;
          end
        end
      end
    end
  end

  // Command decode over the first three fields.
  assign f0_data = text_is(fld[0], TXT_DATA, 3'd4);

  always_comb begin
    verdict.end_cmd = text_is(fld[0], TXT_END, 3'd3);
    verdict.reply   = RPL_NONE;
    if (!verdict.end_cmd) begin
      if (f0_data) begin
        if (text_is(fld[1], TXT_LEDB, 3'd4)) begin
          if (text_is(fld[2], TXT_ON, 3'd2)) begin
            verdict.reply = RPL_SET_OFF;
          end else if (text_is(fld[2], TXT_OFF, 3'd3)) begin
            verdict.reply = RPL_SET_ON;
          end
        end
      end else if (text_is(fld[0], TXT_CONF, 3'd4) &&
                   text_is(fld[1], TXT_LEDB, 3'd4)) begin
        verdict.reply = RPL_END;
      end
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fcr_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 120;
  localparam int REPORT_CAP    = 40;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic [1:0] frame_state;
    logic       end_seen;
  } poll_result_t;

  typedef enum int {
    CMD_ON,
    CMD_OFF,
    CMD_CONF,
    CMD_END,
    CMD_SET,
    CMD_READ,
    CMD_JUNK
  } cmd_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       restart = 1'b0;
  logic       select_active = 1'b0;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       tx_load;
  logic [7:0] tx_byte;
  logic [1:0] frame_state;
  logic       end_seen;

  framed_ascii_command_responder_core #(
    .BUFFER_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .select_active(select_active),
    .rx_valid     (rx_valid),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_load      (tx_load),
    .tx_byte      (tx_byte),
    .frame_state  (frame_state),
    .end_seen     (end_seen)
  );

  always #5 clk = ~clk;

  // Responder state as the predictor sees it.
  frame_t     frame_mode;
  logic [7:0] rx_buf [RING_DEPTH];
  int         rx_wr;
  logic [7:0] ring [RING_DEPTH];
  int         ring_rd;
  int         ring_wr;
  bit         shifter_busy;
  bit         sel_last;

  poll_result_t pending_results [$];
  logic [7:0]   frame_bytes [$];

  int  polls_sent      = 0;
  int  results_checked = 0;
  int  error_count     = 0;
  int  replies_queued  = 0;
  int  end_frames      = 0;
  int  clears          = 0;
  int  cycle_count     = 0;
  int  stall_left      = 0;
  bit  idle_on         = 1'b1;
  bit  stall_on        = 1'b1;
  bit  sel_level       = 1'b0;

  function automatic void ring_push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      ring[ring_wr] = s[i];
      ring_wr = (ring_wr + 1) % RING_DEPTH;
    end
  endfunction

  // Wipe everything and queue the greeting.
  function automatic void clear_responder();
    frame_mode = FS_WAIT;
    for (int i = 0; i < RING_DEPTH; i++) begin
      rx_buf[i] = 8'h00;
      ring[i]   = 8'h00;
    end
    rx_wr        = 0;
    ring_rd      = 0;
    ring_wr      = 0;
    shifter_busy = 1'b0;
    ring_push_text("######!Read;LEDB*");
    clears++;
  endfunction

  // Whole-text compare; a zero byte ends the field text.
  function automatic bit field_is(input logic [8*FIELD_CHARS-1:0] f, input string s);
    logic [7:0] want;
    for (int i = 0; i < FIELD_CHARS; i++) begin
      want = (i < s.len()) ? s[i] : 8'h00;
      if (f[8*i +: 8] != want) return 1'b0;
      if (want == 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Split the closed frame into fields, queue any reply, flag END.
  function automatic bit answer_frame();
    logic [8*FIELD_CHARS-1:0] fld [FIELD_COUNT];
    logic [7:0]               c;
    int                       idx;
    int                       pos;
    for (int k = 0; k < FIELD_COUNT; k++) fld[k] = '0;
    idx = 0;
    pos = 0;
    for (int rp = 0; rp < rx_wr && rx_buf[rp] != CH_END; rp++) begin
      c = rx_buf[rp];
      if (c == CH_DELIM) begin
        pos = 0;
        idx++;
        if (idx >= FIELD_COUNT) idx = FIELD_COUNT - 1;
      end else if (c != CH_START) begin
        fld[idx][8*pos +: 8] = c;
        pos++;
        if (pos >= FIELD_CHARS) pos = FIELD_CHARS - 1;
        fld[idx][8*pos +: 8] = 8'h00;
      end
    end

    if (field_is(fld[0], "END")) begin
      end_frames++;
      return 1'b1;
    end
    if (field_is(fld[0], "Data")) begin
      if (field_is(fld[1], "LEDB")) begin
        if (field_is(fld[2], "On")) begin
          ring_push_text("##!Set;LEDB;Off*");
          replies_queued++;
        end else if (field_is(fld[2], "Off")) begin
          ring_push_text("##!Set;LEDB;On*");
          replies_queued++;
        end
      end
    end else if (field_is(fld[0], "Conf")) begin
      if (field_is(fld[1], "LEDB")) begin
        ring_push_text("##!END*");
        replies_queued++;
      end
    end
    return 1'b0;
  endfunction

  // One poll of the responder: framing, command handling, transmit load, select.
  function automatic poll_result_t step_responder(input bit rs, input bit sel, input bit rv,
                                                  input logic [7:0] b);
    poll_result_t r;
    r = '0;
    if (rs) begin
      clear_responder();
      sel_last = sel;
      return r;
    end

    if (frame_mode == FS_DONE) frame_mode = FS_WAIT;

    if (rv) begin
      shifter_busy = 1'b0;
      if (b == CH_START && frame_mode != FS_IN) begin
        frame_mode = FS_IN;
        rx_wr      = 0;
      end
      if (frame_mode == FS_IN) begin
        rx_buf[rx_wr] = b;
        rx_wr++;
        if (rx_wr >= RING_DEPTH) rx_wr = RING_DEPTH - 1;
        if (b == CH_END) frame_mode = FS_DONE;
      end
    end

    if (frame_mode == FS_DONE) r.end_seen = answer_frame();

    if (!shifter_busy) begin
      r.tx_load    = 1'b1;
      shifter_busy = 1'b1;
      if (ring_rd != ring_wr) begin
        r.tx_byte = ring[ring_rd];
        ring_rd   = (ring_rd + 1) % RING_DEPTH;
      end
    end

    r.frame_state = frame_mode;
    if (sel && !sel_last) clear_responder();
    sel_last = sel;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display("MISMATCH %s on result %0d: got %0h, expected %0h",
               what, results_checked, got, want);
  endtask

  // Send one request, with an occasional idle burst ahead of it.
  task automatic send_poll(input bit rs, input bit sel, input bit rv, input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    restart       <= rs;
    select_active <= sel;
    rx_valid      <= rv;
    rx_byte       <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(step_responder(rs, sel, rv, b));
    polls_sent++;
  endtask

  // Hold off until every pending result has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(8'h41, 8'h7A));
  endfunction

  task automatic send_frame_bytes();
    while (frame_bytes.size() > 0) send_poll(1'b0, sel_level, 1'b1, frame_bytes.pop_front());
  endtask

  // A command frame, sometimes bent: stray start mark, extra fields, an
  // overlong run of text, a flipped bit, or no closing mark at all.
  function automatic void build_command_frame();
    cmd_kind_t kind;
    int        pos;
    frame_bytes.delete();
    kind = cmd_kind_t'($urandom_range(0, 6));
    frame_bytes.push_back(CH_START);
    case (kind)
      CMD_ON:   add_text("Data;LEDB;On");
      CMD_OFF:  add_text("Data;LEDB;Off");
      CMD_CONF: add_text("Conf;LEDB");
      CMD_END:  add_text("END");
      CMD_SET:  add_text("Set;LEDB;On");
      CMD_READ: add_text("Read;LEDB");
      default: begin
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(rand_letter());
      end
    endcase
    if ($urandom_range(0, 7) == 0)
      frame_bytes.insert($urandom_range(1, frame_bytes.size()), CH_START);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(2, 5)) begin
        frame_bytes.push_back(CH_DELIM);
        frame_bytes.push_back(rand_letter());
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, frame_bytes.size());
      repeat ($urandom_range(5, 14)) frame_bytes.insert(pos, rand_letter());
    end
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 11) != 0) frame_bytes.push_back(CH_END);
  endfunction

  // A frame that fills the receive store or runs past it, so the write position saturates.
  function automatic void build_long_frame();
    logic [7:0] c;
    frame_bytes.delete();
    frame_bytes.push_back(CH_START);
    repeat ($urandom_range(62, 75)) begin
      c = 8'($urandom);
      if (c == CH_END) c = rand_letter();
      frame_bytes.push_back(c);
    end
    frame_bytes.push_back(CH_END);
  endfunction

  task automatic test_idle_and_extremes();
    send_poll(1'b0, 1'b0, 1'b0, 8'hFF);
    send_poll(1'b0, 1'b0, 1'b1, 8'h00);
    send_poll(1'b0, 1'b0, 1'b1, 8'hFF);
  endtask

  task automatic test_end_command();
    frame_bytes.delete();
    add_text("!END*");
    send_frame_bytes();
  endtask

  task automatic test_conf_command();
    frame_bytes.delete();
    add_text("!Conf;LEDB*");
    send_frame_bytes();
  endtask

  task automatic test_restart_and_select();
    sel_level = 1'b0;
    send_poll(1'b1, 1'b0, 1'b0, 8'hFF);
    // Restart with select already high: the held level must not clear again.
    sel_level = 1'b1;
    send_poll(1'b1, 1'b1, 1'b1, CH_START);
    send_poll(1'b0, 1'b1, 1'b1, CH_START);
    sel_level = 1'b0;
    send_poll(1'b0, 1'b0, 1'b1, CH_DELIM);
    // Rising select: the poll is reported, then everything clears.
    sel_level = 1'b1;
    send_poll(1'b0, 1'b1, 1'b1, CH_END);
    send_poll(1'b0, 1'b1, 1'b0, 8'h00);
  endtask

  // Replies outpace the one-byte-per-request drain until the ring wraps.
  task automatic test_ring_overflow();
    send_poll(1'b1, sel_level, 1'b0, 8'h00);
    repeat (25) begin
      frame_bytes.delete();
      add_text("!Data;LEDB;On*");
      send_frame_bytes();
    end
  endtask

  task automatic test_random_traffic(input int n_polls);
    int stop_at;
    int pick;
    stop_at = polls_sent + n_polls;
    while (polls_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        build_command_frame();
        send_frame_bytes();
      end else if (pick < 61) begin
        build_long_frame();
        send_frame_bytes();
      end else if (pick < 92) begin
        send_poll(1'b0, sel_level, 1'($urandom_range(0, 1)), 8'($urandom));
      end else if (pick < 95) begin
        sel_level = 1'($urandom_range(0, 1));
        send_poll(1'b1, sel_level, 1'($urandom_range(0, 1)), 8'($urandom));
      end else begin
        sel_level = ~sel_level;
        send_poll(1'b0, sel_level, 1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  // Receiver stalls in short random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each returned result with the oldest prediction.
  always @(posedge clk) begin
    poll_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", tx_byte, 0);
      end else begin
        want = pending_results.pop_front();
        if (tx_load !== want.tx_load) report_mismatch("tx_load", tx_load, want.tx_load);
        if (tx_byte !== want.tx_byte) report_mismatch("tx_byte", tx_byte, want.tx_byte);
        if (frame_state !== want.frame_state)
          report_mismatch("frame_state", frame_state, want.frame_state);
        if (end_seen !== want.end_seen) report_mismatch("end_seen", end_seen, want.end_seen);
      end
      results_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("framed_ascii_command_responder_core verification failed");
      $finish;
    end
  end

  initial begin
    clear_responder();
    sel_last = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_extremes();
    test_end_command();
    test_conf_command();
    test_restart_and_select();
    wait_until_drained();
    test_ring_overflow();
    test_random_traffic(120);

    // Final stretch runs with both sides always ready.
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(60);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results over %0d clears.",
             polls_sent, results_checked, clears);
    $display("Frames answered with a reply: %0d, END frames: %0d.", replies_queued, end_frames);
    if (error_count == 0) begin
      $display("framed_ascii_command_responder_core verification clean");
    end else begin
      $display("framed_ascii_command_responder_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fcr_pkg.sv
rtl/fcr_split.sv
rtl/framed_ascii_command_responder_core.sv
tb/testbench.sv
